// ===== hw/rtl/wpfs_pkg.sv =====
`default_nettype none

package wpfs_pkg;

    // CORDIC datapath widths: x/y carry the 2^16 pre-scale of atan2, z is a Q8.16 angle.
    localparam int XW = 52;
    localparam int ZW = 24;
    localparam int IW = 34;
    localparam int TAB_LEN = 24;

    localparam logic signed [ZW-1:0] ANG_HALF_PI = 24'sd102944;
    localparam logic signed [ZW-1:0] ANG_PI      = 24'sd205887;
    localparam logic signed [ZW-1:0] ANG_TWO_PI  = 24'sd411775;
    localparam logic signed [ZW-1:0] ANG_TEN_DEG = 24'sd11438;
    localparam logic signed [16:0]   INV_GAIN_Q16 = 17'sd39797;

    typedef enum logic [1:0] {
        FN_LOAD = 2'd0,
        FN_ODOM = 2'd1,
        FN_TICK = 2'd2,
        FN_NOP  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        CFG_MAX_LINEAR  = 2'd0,
        CFG_MAX_ANGULAR = 2'd1,
        CFG_REACH       = 2'd2,
        CFG_GAIN        = 2'd3
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ATAN_ODO,
        ST_ROT_START,
        ST_ROT_WAIT,
        ST_MUL_X,
        ST_MUL_Y,
        ST_SQ_F,
        ST_SQ_L,
        ST_SQ_R,
        ST_REACH,
        ST_ATAN_TICK,
        ST_GAIN,
        ST_TICK_FIN,
        ST_OUT
    } state_t;

    // Arctangent of 2^-i in Q0.16 radians.
    function automatic logic [15:0] atan_entry(input logic [4:0] i);
        logic [15:0] v;
        case (i)
            5'd0:    v = 16'd51472;
            5'd1:    v = 16'd30385;
            5'd2:    v = 16'd16055;
            5'd3:    v = 16'd8150;
            5'd4:    v = 16'd4091;
            5'd5:    v = 16'd2047;
            5'd6:    v = 16'd1024;
            5'd7:    v = 16'd512;
            5'd8:    v = 16'd256;
            5'd9:    v = 16'd128;
            5'd10:   v = 16'd64;
            5'd11:   v = 16'd32;
            5'd12:   v = 16'd16;
            5'd13:   v = 16'd8;
            5'd14:   v = 16'd4;
            5'd15:   v = 16'd2;
            5'd16:   v = 16'd1;
            5'd17:   v = 16'd1;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/waypoint_follow_steering_core.sv =====
`default_nettype none

// Channel    | Dir | Handshake               | Payload
// s_axis     | in  | tvalid/tready           | tuser: func; tdata: pos_x, pos_y, quat_z, quat_w
// m_axis     | out | tvalid/tready           | tuser: cmd_valid, table_full;
//            |     |                         | tdata: linear_cmd, angular_cmd, target_index
// cfg        | in  | cfg_we                  | cfg_addr, cfg_wdata
//
// One item is taken at a time; s_axis_tready is high only while the sequencer is idle.
// A load or no-op item, or odometry with no waypoints loaded, goes straight to the output state.
// A tick makes one pass and an odometry item two through the single shared CORDIC unit.
// A finished result waits in the output register; if it has not been taken, the next
// result holds the sequencer until it has. Reset is asynchronous and clears all control
// state and counters; the waypoint memory is not cleared and only written entries are used.
module waypoint_follow_steering_core
    import wpfs_pkg::*;
#(
    parameter int MAX_WAYPOINTS = 256,
    parameter int CORDIC_STEPS  = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [95:0] s_axis_tdata,   // pos_x, pos_y, quat_z, quat_w
    input  wire logic [1:0]  s_axis_tuser,   // func
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata,   // linear_cmd, angular_cmd, target_index
    output logic [1:0]       m_axis_tuser,   // cmd_valid, table_full
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [30:0] cfg_wdata
);

    localparam int AW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
    localparam int CW = $clog2(MAX_WAYPOINTS + 1);

    state_t state_reg, state_next;

    // Configuration registers.
    logic [30:0] max_lin_reg, max_ang_reg, reach_reg;
    logic [15:0] gain_reg;

    // Block state.
    logic [CW-1:0]      count_reg;
    logic [AW-1:0]      target_reg;
    logic signed [31:0] fwd_reg, lat_reg;

    // Waypoint memory: {y, x}.
    logic [63:0] wp_mem [MAX_WAYPOINTS];
    logic [63:0] wp_rd_reg;

    // Latched input item.
    logic [1:0]         func_reg;
    logic signed [31:0] px_reg, py_reg;

    // Arithmetic scratch.
    logic signed [52:0] prod_reg;
    logic [63:0]        sq_reg;
    logic [64:0]        acc_reg;
    logic signed [ZW-1:0] th_reg;

    // Result staging and output register.
    logic signed [31:0] lin_reg, ang_reg;
    logic               valid_reg, full_reg;
    logic               m_valid_reg;
    logic [71:0]        m_data_reg;
    logic [1:0]         m_user_reg;

    logic accept;
    logic out_free;

    // CORDIC hookup.
    logic                 cor_start, cor_rotate, cor_busy, cor_done;
    logic signed [IW-1:0] cor_x, cor_y;
    logic signed [ZW-1:0] cor_z;
    logic signed [XW-1:0] cor_xo, cor_yo;
    logic signed [ZW-1:0] cor_zo;

    // Shared multipliers.
    logic signed [35:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [32:0] sq_a;
    logic signed [65:0] sq_p;

    logic signed [36:0] scaled;
    logic signed [31:0] sat_val;
    logic signed [44:0] ang_raw, ang_lim;
    logic signed [32:0] lin_lim, fwd_ext;
    logic signed [31:0] lin_val, ang_val;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !m_valid_reg || m_axis_tready;

    wpfs_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cor_start),
        .rotate (cor_rotate),
        .x_in   (cor_x),
        .y_in   (cor_y),
        .z_in   (cor_z),
        .busy   (cor_busy),
        .done   (cor_done),
        .x_out  (cor_xo),
        .y_out  (cor_yo),
        .z_out  (cor_zo)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (accept)
                begin
                    if (s_axis_tuser == FN_ODOM && count_reg != '0)
                        state_next = ST_ATAN_ODO;
                    else if (s_axis_tuser == FN_TICK)
                        state_next = ST_ATAN_TICK;
                    else
                        state_next = ST_OUT;
                end
            ST_ATAN_ODO:  if (cor_done) state_next = ST_ROT_START;
            ST_ROT_START: state_next = ST_ROT_WAIT;
            ST_ROT_WAIT:  if (cor_done) state_next = ST_MUL_X;
            ST_MUL_X:     state_next = ST_MUL_Y;
            ST_MUL_Y:     state_next = ST_SQ_F;
            ST_SQ_F:      state_next = ST_SQ_L;
            ST_SQ_L:      state_next = ST_SQ_R;
            ST_SQ_R:      state_next = ST_REACH;
            ST_REACH:     state_next = ST_OUT;
            ST_ATAN_TICK: if (cor_done) state_next = ST_GAIN;
            ST_GAIN:      state_next = ST_TICK_FIN;
            ST_TICK_FIN:  state_next = ST_OUT;
            ST_OUT:       if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: input ready, CORDIC start and operands, and multiplier operand selection.
    always_comb
    begin
        s_axis_tready = (state_reg == ST_IDLE);
        cor_start  = 1'b0;
        cor_rotate = 1'b0;
        cor_x = IW'(signed'(s_axis_tdata[95:80]));
        cor_y = IW'(signed'(s_axis_tdata[79:64]));
        cor_z = '0;
        mul_a = 36'(cor_xo);
        mul_b = INV_GAIN_Q16;
        sq_a  = 33'(fwd_reg);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && s_axis_tuser == FN_ODOM && count_reg != '0)
                    cor_start = 1'b1;
                if (accept && s_axis_tuser == FN_TICK)
                begin
                    cor_start = 1'b1;
                    cor_x = IW'(fwd_reg);
                    cor_y = IW'(lat_reg);
                end
            end
            ST_ROT_START:
            begin
                cor_start  = 1'b1;
                cor_rotate = 1'b1;
                cor_x = IW'(signed'(wp_rd_reg[31:0])) - IW'(px_reg);
                cor_y = IW'(signed'(wp_rd_reg[63:32])) - IW'(py_reg);
                cor_z = -(cor_zo <<< 1);
            end
            ST_MUL_Y: mul_a = 36'(cor_yo);
            ST_SQ_L:  sq_a = 33'(lat_reg);
            ST_SQ_R:  sq_a = signed'({2'b00, reach_reg});
            ST_GAIN:
            begin
                mul_a = 36'(th_reg);
                mul_b = signed'({1'b0, gain_reg});
            end
            default: ;
        endcase
    end

    assign sq_p   = sq_a * sq_a;
    assign scaled = prod_reg[52:16];

    always_comb
    begin
        if (scaled > 37'sd2147483647)
            sat_val = 32'sh7FFFFFFF;
        else if (scaled < -37'sd2147483648)
            sat_val = 32'sh80000000;
        else
            sat_val = scaled[31:0];

        ang_raw = prod_reg[52:8];
        ang_lim = signed'({14'b0, max_ang_reg});
        if (ang_raw > ang_lim)
            ang_val = 32'(ang_lim);
        else if (ang_raw < -ang_lim)
            ang_val = 32'(-ang_lim);
        else
            ang_val = ang_raw[31:0];

        fwd_ext = 33'(fwd_reg);
        lin_lim = signed'({2'b0, max_lin_reg});
        if (th_reg > ANG_TEN_DEG)
            lin_val = '0;
        else if (fwd_ext > lin_lim)
            lin_val = 32'(lin_lim);
        else if (fwd_ext < -lin_lim)
            lin_val = 32'(-lin_lim);
        else
            lin_val = fwd_reg;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            target_reg  <= '0;
            fwd_reg     <= '0;
            lat_reg     <= '0;
            m_valid_reg <= 1'b0;
            max_lin_reg <= 31'd327680;
            max_ang_reg <= 31'd65536;
            reach_reg   <= 31'd32768;
            gain_reg    <= 16'd1280;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index_t'(cfg_addr))
                    CFG_MAX_LINEAR:  max_lin_reg <= cfg_wdata;
                    CFG_MAX_ANGULAR: max_ang_reg <= cfg_wdata;
                    CFG_REACH:       reach_reg   <= cfg_wdata;
                    CFG_GAIN:        gain_reg    <= cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (accept && s_axis_tuser == FN_LOAD && count_reg < CW'(MAX_WAYPOINTS))
                count_reg <= count_reg + 1'b1;
            if (state_reg == ST_MUL_Y)
                fwd_reg <= sat_val;
            if (state_reg == ST_SQ_F)
                lat_reg <= sat_val;
            if (state_reg == ST_REACH && acc_reg < {1'b0, sq_reg}
                && CW'(target_reg) + 1'b1 < count_reg)
                target_reg <= target_reg + 1'b1;
            if (state_reg == ST_OUT && out_free)
                m_valid_reg <= 1'b1;
            else if (m_axis_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // Memory and datapath registers.
    always_ff @(posedge clk)
    begin
        if (accept && s_axis_tuser == FN_LOAD && count_reg < CW'(MAX_WAYPOINTS))
            wp_mem[count_reg[AW-1:0]] <= {s_axis_tdata[63:32], s_axis_tdata[31:0]};
        wp_rd_reg <= wp_mem[target_reg];

        if (accept)
        begin
            func_reg  <= s_axis_tuser;
            px_reg    <= s_axis_tdata[31:0];
            py_reg    <= s_axis_tdata[63:32];
            lin_reg   <= '0;
            ang_reg   <= '0;
            valid_reg <= 1'b0;
            full_reg  <= (s_axis_tuser == FN_LOAD) && !(count_reg < CW'(MAX_WAYPOINTS));
        end

        prod_reg <= mul_a * mul_b;
        sq_reg   <= sq_p[63:0];
        if (state_reg == ST_SQ_L)
            acc_reg <= {1'b0, sq_reg};
        else if (state_reg == ST_SQ_R)
            acc_reg <= acc_reg + {1'b0, sq_reg};

        if (state_reg == ST_ATAN_TICK && cor_done)
            th_reg <= cor_zo;

        if (state_reg == ST_TICK_FIN && func_reg == FN_TICK && count_reg != '0)
        begin
            lin_reg   <= lin_val;
            ang_reg   <= ang_val;
            valid_reg <= 1'b1;
        end

        if (state_reg == ST_OUT && out_free)
        begin
            m_data_reg <= {8'(target_reg), ang_reg, lin_reg};
            m_user_reg <= {full_reg, valid_reg};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    // The table never holds more than its depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_WAYPOINTS))
        else $error("waypoint count beyond table depth");

    // The target always points at a loaded waypoint once any exist.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 || CW'(target_reg) < count_reg)
        else $error("target beyond loaded waypoints");

    // The CORDIC unit is never mid-run while a new item may be accepted.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !cor_busy)
        else $error("CORDIC busy while idle");

    // A CORDIC completion only arrives in a state that waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        cor_done |-> (state_reg == ST_ATAN_ODO || state_reg == ST_ROT_WAIT
                      || state_reg == ST_ATAN_TICK))
        else $error("unexpected CORDIC completion");

endmodule

`default_nettype wire

// ===== hw/rtl/wpfs_cordic.sv =====
`default_nettype none

// Iterative CORDIC, one micro-rotation per cycle. Vectoring mode returns
// atan2(y_in, x_in); rotation mode turns (x_in, y_in) by z_in.
module wpfs_cordic
    import wpfs_pkg::*;
#(
    parameter int STEPS = 16
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic                 rotate,
    input  wire logic signed [IW-1:0] x_in,
    input  wire logic signed [IW-1:0] y_in,
    input  wire logic signed [ZW-1:0] z_in,
    output logic                      busy,
    output logic                      done,
    output logic signed [XW-1:0]      x_out,
    output logic signed [XW-1:0]      y_out,
    output logic signed [ZW-1:0]      z_out
);

    localparam int NSTEP = (STEPS < TAB_LEN) ? STEPS : TAB_LEN;

    logic signed [XW-1:0] x_reg, y_reg, x_next, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic [4:0]           cnt_reg;
    logic                 busy_reg, done_reg, rot_reg, zero_reg;

    logic signed [XW-1:0] xs, ys, dx, dy;
    logic signed [ZW-1:0] a0, a1, tab;

    always_comb
    begin
        xs = XW'(x_in);
        ys = XW'(y_in);
        a0 = z_in;
        if (a0 > ANG_PI)
            a0 = a0 - ANG_TWO_PI;
        else if (a0 <= -ANG_PI)
            a0 = a0 + ANG_TWO_PI;
        a1 = a0;
        x_next = xs;
        y_next = ys;
        z_next = '0;
        if (rotate)
        begin
            if (a0 > ANG_HALF_PI)
            begin
                x_next = -xs;
                y_next = -ys;
                a1 = a0 - ANG_PI;
            end
            else if (a0 < -ANG_HALF_PI)
            begin
                x_next = -xs;
                y_next = -ys;
                a1 = a0 + ANG_PI;
            end
            z_next = a1;
        end
        else
        begin
            x_next = xs <<< 16;
            y_next = ys <<< 16;
            if (xs < 0)
            begin
                if (ys >= 0)
                begin
                    x_next = ys <<< 16;
                    y_next = -(xs <<< 16);
                    z_next = ANG_HALF_PI;
                end
                else
                begin
                    x_next = -(ys <<< 16);
                    y_next = xs <<< 16;
                    z_next = -ANG_HALF_PI;
                end
            end
        end
    end

    assign dx  = y_reg >>> cnt_reg;
    assign dy  = x_reg >>> cnt_reg;
    assign tab = ZW'(atan_entry(cnt_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= '0;
                if (!rotate && x_in == '0 && y_in == '0)
                    done_reg <= 1'b1;
                else
                    busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(NSTEP - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            rot_reg  <= rotate;
            zero_reg <= !rotate && x_in == '0 && y_in == '0;
        end
        else if (busy_reg)
        begin
            if (rot_reg ? (z_reg >= 0) : !(y_reg > 0))
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= rot_reg ? z_reg - tab : z_reg - tab;
            end
            else
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + tab;
            end
        end
    end

    assign busy  = busy_reg;
    assign done  = done_reg;
    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = zero_reg ? '0 : z_reg;

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import wpfs_pkg::*;

    localparam int TABLE_DEPTH = 256;
    localparam int ANGLE_STEPS = 16;
    localparam longint CYCLE_LIMIT = 1000000;

    // Arctangent of 2^-i, Q16.16 radians, as the datapath uses it.
    localparam longint ATAN_TAB [24] = '{
        51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2,
        1, 1, 0, 0, 0, 0, 0, 0
    };

    // One steering result as it leaves the block.
    typedef struct {
        logic signed [31:0] lin;
        logic signed [31:0] ang;
        logic               valid;
        logic [7:0]         tgt;
        logic               full;
    } cmd_t;

    // One row of the directed stimulus; typed rows carry their own result.
    typedef struct {
        logic [1:0]  fn;
        logic [31:0] px;
        logic [31:0] py;
        logic [15:0] qz;
        logic [15:0] qw;
        bit          typed;
        cmd_t        res;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;   // pos_x, pos_y, quat_z, quat_w
    logic [1:0]  s_axis_tuser = '0;   // func
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;        // linear_cmd, angular_cmd, target_index
    logic [1:0]  m_axis_tuser;        // cmd_valid, table_full
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [30:0] cfg_wdata = '0;

    waypoint_follow_steering_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Shadow copy of the steering state, updated as each item is accepted.
    int          wp_x [TABLE_DEPTH];
    int          wp_y [TABLE_DEPTH];
    int unsigned wp_count;
    int unsigned cur_target;
    int          dir_fwd;
    int          dir_lat;
    longint      lim_linear;
    longint      lim_angular;
    longint      reach_r;
    longint      turn_gain;

    cmd_t   cmd_expect_q [$];
    int     mismatches = 0;
    int     items_sent = 0;
    int     results_seen = 0;
    int     drops_seen = 0;
    int     advances_seen = 0;
    longint cycles = 0;

    // Traffic shaping: calm turns all idling off, hold_req asks the result
    // side for one long hold-off.
    bit calm = 1'b0;
    bit hold_req = 1'b0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    function automatic int sat_word(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return int'(v);
    endfunction

    function automatic longint clamp_mag(longint v, longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    // Vectoring CORDIC: returns atan2(y, x) in Q16.16 radians.
    function automatic longint heading_of(longint y, longint x);
        longint z;
        longint t;
        longint dx;
        longint dy;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        x = x * 65536;
        y = y * 65536;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                z = ANG_HALF_PI;
            end
            else
            begin
                x = -y;
                y = t;
                z = -ANG_HALF_PI;
            end
        end
        for (int i = 0; i < ANGLE_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_TAB[i];
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_TAB[i];
            end
        end
        return z;
    endfunction

    // Rotation CORDIC by angle a, with the CORDIC gain taken back out.
    function automatic void rotate_vec(inout longint x, inout longint y, input longint a);
        longint dx;
        longint dy;
        while (a > ANG_PI)
            a = a - ANG_TWO_PI;
        while (a <= -ANG_PI)
            a = a + ANG_TWO_PI;
        if (a > ANG_HALF_PI)
        begin
            x = -x;
            y = -y;
            a = a - ANG_PI;
        end
        else if (a < -ANG_HALF_PI)
        begin
            x = -x;
            y = -y;
            a = a + ANG_PI;
        end
        for (int i = 0; i < ANGLE_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (a >= 0)
            begin
                x = x - dx;
                y = y + dy;
                a = a - ATAN_TAB[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                a = a + ATAN_TAB[i];
            end
        end
        x = (x * INV_GAIN_Q16) >>> 16;
        y = (y * INV_GAIN_Q16) >>> 16;
    endfunction

    // Advances the shadow state by one item and returns the command it yields.
    function automatic cmd_t steer_step(logic [1:0] fn, int px, int py,
                                        shortint qz, shortint qw);
        cmd_t   c;
        longint yaw;
        longint vx;
        longint vy;
        longint th;
        longint unsigned f2;
        longint unsigned l2;
        longint unsigned r2;
        c.lin = '0;
        c.ang = '0;
        c.valid = 1'b0;
        c.full = 1'b0;
        case (fn)
            FN_LOAD:
            begin
                if (wp_count < TABLE_DEPTH)
                begin
                    wp_x[wp_count] = px;
                    wp_y[wp_count] = py;
                    wp_count++;
                end
                else
                    c.full = 1'b1;
            end
            FN_ODOM:
            begin
                if (wp_count > 0)
                begin
                    yaw = 2 * heading_of(longint'(qz), longint'(qw));
                    vx = longint'(wp_x[cur_target]) - longint'(px);
                    vy = longint'(wp_y[cur_target]) - longint'(py);
                    rotate_vec(vx, vy, -yaw);
                    dir_fwd = sat_word(vx);
                    dir_lat = sat_word(vy);
                    f2 = longint'(dir_fwd) * longint'(dir_fwd);
                    l2 = longint'(dir_lat) * longint'(dir_lat);
                    r2 = reach_r * reach_r;
                    if (f2 + l2 < r2 && cur_target + 1 < wp_count)
                    begin
                        cur_target++;
                        advances_seen++;
                    end
                end
            end
            FN_TICK:
            begin
                th = heading_of(longint'(dir_lat), longint'(dir_fwd));
                // Only a turn to the left beyond ten degrees stops the robot.
                if (th > ANG_TEN_DEG)
                    c.lin = '0;
                else
                    c.lin = 32'(clamp_mag(longint'(dir_fwd), lim_linear));
                c.ang = 32'(clamp_mag((turn_gain * th) >>> 8, lim_angular));
                if (wp_count > 0)
                    c.valid = 1'b1;
                else
                begin
                    c.lin = '0;
                    c.ang = '0;
                end
            end
            default:
            begin
            end
        endcase
        c.tgt = cur_target[7:0];
        return c;
    endfunction

    // Offers one item, waits for it to be taken and records what it should yield.
    task automatic send_item(input logic [1:0] fn, input logic [31:0] px, input logic [31:0] py,
                             input logic [15:0] qz, input logic [15:0] qw,
                             input bit typed, input cmd_t typed_res);
        cmd_t p;
        int   gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {qw, qz, py, px};
        s_axis_tuser <= fn;
        do
            @(posedge clk);
        while (!s_axis_tready);
        p = steer_step(fn, px, py, qz, qw);
        cmd_expect_q.push_back(typed ? typed_res : p);
        items_sent++;
    endtask

    // Lowers valid, waits until every result is back and the block has settled.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        wait (cmd_expect_q.size() == 0);
        repeat (80) @(posedge clk);
    endtask

    // Presents one register write for a single edge; the caller lowers the enable.
    task automatic write_reg(input cfg_index_t idx, input logic [30:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            CFG_MAX_LINEAR:  lim_linear = val;
            CFG_MAX_ANGULAR: lim_angular = val;
            CFG_REACH:       reach_r = val;
            CFG_GAIN:        turn_gain = val[15:0];
        endcase
    endtask

    task automatic configure(input logic [30:0] lin, input logic [30:0] ang,
                             input logic [30:0] reach, input logic [15:0] gain);
        drain();
        write_reg(CFG_MAX_LINEAR, lin);
        write_reg(CFG_MAX_ANGULAR, ang);
        write_reg(CFG_REACH, reach);
        write_reg(CFG_GAIN, {15'd0, gain});
        cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] rand_quat();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 16'shC000;
        if (r == 1)
            return 16'sh4000;
        return 16'($urandom_range(0, 32768) - 16384);
    endfunction

    // Positions mostly inside a few tens of metres, now and then anywhere.
    function automatic logic [31:0] rand_pos();
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return 32'($urandom_range(0, 32'h00400000) - 32'h00200000);
    endfunction

    // Random traffic: odometry mostly lands close to the current target so
    // that the reach test passes and the target walks down the table.
    task automatic random_items(input int n, input int pct_load);
        int          r;
        logic [1:0]  fn;
        logic [31:0] px;
        logic [31:0] py;
        cmd_t        none;
        none = '{default: '0};
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < pct_load)
                fn = FN_LOAD;
            else if (r < pct_load + (100 - pct_load) * 55 / 100)
                fn = FN_ODOM;
            else if (r < 96)
                fn = FN_TICK;
            else
                fn = FN_NOP;
            px = rand_pos();
            py = rand_pos();
            if (fn == FN_ODOM && wp_count > 0 && $urandom_range(0, 99) < 70)
            begin
                px = wp_x[cur_target] + $urandom_range(0, 16'hC000) - 16'h6000;
                py = wp_y[cur_target] + $urandom_range(0, 16'hC000) - 16'h6000;
            end
            send_item(fn, px, py, rand_quat(), rand_quat(), 1'b0, none);
        end
    endtask

    // Result side: checks every accepted result, then decides its next ready.
    int stall_left = 0;
    int hold_left = 0;

    always @(posedge clk)
    begin
        cmd_t want;
        cmd_t got;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.lin = m_axis_tdata[31:0];
                got.ang = m_axis_tdata[63:32];
                got.tgt = m_axis_tdata[71:64];
                got.valid = m_axis_tuser[0];
                got.full = m_axis_tuser[1];
                results_seen++;
                if (got.full === 1'b1)
                    drops_seen++;
                if (cmd_expect_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result with nothing outstanding at cycle %0d", cycles);
                end
                else
                begin
                    want = cmd_expect_q.pop_front();
                    if (got.lin !== want.lin || got.ang !== want.ang
                        || got.valid !== want.valid || got.tgt !== want.tgt
                        || got.full !== want.full)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch #%0d cycle %0d: exp lin %0d ang %0d",
                                      " vld %b tgt %0d full %b, got lin %0d ang %0d",
                                      " vld %b tgt %0d full %b"},
                                     mismatches, cycles, want.lin, want.ang, want.valid,
                                     want.tgt, want.full, got.lin, got.ang, got.valid,
                                     got.tgt, got.full);
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = 300;
                m_axis_tready <= 1'b0;
            end
            else if (calm)
                m_axis_tready <= 1'b1;
            else if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if ($urandom_range(0, 99) < 30)
            begin
                stall_left = pick_gap();
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, cmd_expect_q.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    row_t rows [$];

    task automatic add_row(input logic [1:0] fn, input logic [31:0] px, input logic [31:0] py,
                           input logic [15:0] qz, input logic [15:0] qw,
                           input bit typed, input logic [7:0] tgt);
        row_t r;
        r.fn = fn;
        r.px = px;
        r.py = py;
        r.qz = qz;
        r.qw = qw;
        r.typed = typed;
        r.res = '{default: '0};
        r.res.tgt = tgt;
        rows.push_back(r);
    endtask

    initial
    begin
        wp_count = 0;
        cur_target = 0;
        dir_fwd = 0;
        dir_lat = 0;
        lim_linear = 327680;
        lim_angular = 65536;
        reach_r = 32768;
        turn_gain = 1280;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset configuration. With the table empty, ticks,
        // odometry and no-ops all give the all-zero command.
        add_row(FN_TICK, 0, 0, 0, 0, 1'b1, 0);
        add_row(FN_ODOM, 32'h00010000, 32'h00010000, 0, 16'h4000, 1'b1, 0);
        add_row(FN_NOP, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hC000, 16'hC000, 1'b1, 0);
        // Two loads at the corners of the position range, one near the origin.
        add_row(FN_LOAD, 32'h80000000, 32'h7FFFFFFF, 16'h4000, 16'hC000, 1'b1, 0);
        add_row(FN_LOAD, 32'h7FFFFFFF, 32'h80000000, 0, 0, 1'b1, 0);
        add_row(FN_LOAD, 32'h00020000, 32'h00010000, 0, 0, 1'b1, 0);
        // Opposite corner: the difference needs 33 bits and saturates.
        add_row(FN_ODOM, 32'h7FFFFFFF, 32'h80000000, 0, 16'h4000, 1'b0, 0);
        add_row(FN_TICK, 0, 0, 0, 0, 1'b0, 0);
        // Yaw of +pi, -pi and w negative, i.e. the quadrant fix-ups.
        add_row(FN_ODOM, 0, 0, 16'h4000, 0, 1'b0, 0);
        add_row(FN_TICK, 0, 0, 0, 0, 1'b0, 0);
        add_row(FN_ODOM, 0, 0, 16'hC000, 0, 1'b0, 0);
        add_row(FN_TICK, 0, 0, 0, 0, 1'b0, 0);
        add_row(FN_ODOM, 32'h00050000, 32'hFFFB0000, 0, 16'hC000, 1'b0, 0);
        // Zero quaternion and a robot sitting on its target: heading of a
        // zero vector is zero and the target advances.
        add_row(FN_ODOM, 32'h80000000, 32'h7FFFFFFF, 0, 0, 1'b0, 0);
        add_row(FN_TICK, 0, 0, 0, 0, 1'b0, 0);
        add_row(FN_ODOM, 32'h7FFFF000, 32'h80001000, 0, 16'h4000, 1'b0, 0);
        // Target now the last point: right turn, left turn, straight ahead.
        add_row(FN_ODOM, 32'h00020000, 32'h00030000, 0, 16'h4000, 1'b0, 0);
        add_row(FN_TICK, 0, 0, 0, 0, 1'b0, 0);
        add_row(FN_ODOM, 32'h00020000, 32'h00000000, 0, 16'h4000, 1'b0, 0);
        add_row(FN_TICK, 0, 0, 0, 0, 1'b0, 0);
        add_row(FN_ODOM, 32'h00010000, 32'h00010000, 0, 16'h4000, 1'b0, 0);
        add_row(FN_TICK, 0, 0, 0, 0, 1'b0, 0);
        add_row(FN_NOP, 32'hFFFFFFFF, 32'h00000000, 16'hC000, 16'h4000, 1'b1, 2);
        foreach (rows[i])
            send_item(rows[i].fn, rows[i].px, rows[i].py, rows[i].qz, rows[i].qw,
                      rows[i].typed, rows[i].res);

        // Wide limits and the largest gain, with a stretch of back-to-back traffic.
        configure(31'h7FFFFFFF, 31'h7FFFFFFF, 31'h00010000, 16'hFFFF);
        calm = 1'b1;
        random_items(60, 30);
        calm = 1'b0;
        random_items(190, 30);

        // Result side holds off for a long while; the input must back up.
        hold_req = 1'b1;
        random_items(20, 20);

        // All limits and the gain at zero.
        configure(31'd0, 31'd0, 31'd0, 16'd0);
        random_items(100, 25);

        // Largest reach: odometry nearly always advances the target while a later point
        // is loaded. Heavy loading fills the table and then drops points.
        configure(31'h00030000, 31'h00008000, 31'h7FFFFFFF, 16'h0100);
        random_items(260, 60);

        // A few random settings.
        for (int p = 0; p < 3; p++)
        begin
            configure(31'($urandom), 31'($urandom_range(0, 31'h00080000)),
                      31'($urandom_range(0, 31'h00040000)), 16'($urandom));
            random_items(40, 10);
        end

        s_axis_tvalid <= 1'b0;
        wait (cmd_expect_q.size() == 0);
        repeat (100) @(posedge clk);

        $display("%0d items sent, %0d results checked, %0d target advances, %0d dropped loads",
                 items_sent, results_seen, advances_seen, drops_seen);
        $display("covered empty table, saturating odometry, all yaw quadrants, full table, %0d %s",
                 mismatches, "mismatches");
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
